// ===== src/quaternion_vertical_accel_defines.svh =====
// ----------------------------------------------------------------------------
// quaternion_vertical_accel_defines.svh
// Assertion macros shared by the vertical acceleration block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VERTICAL_ACCEL_DEFINES_SVH
`define QUATERNION_VERTICAL_ACCEL_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define QVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define QVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qva_pkg
// Types, constants and helpers for the vertical acceleration pipeline.
// ----------------------------------------------------------------------------
package qva_pkg;

    localparam int QUAT_FRAC_BITS = 30;
    localparam int NUM_LANES      = 3;
    localparam int DIV_STEPS      = 32;

    localparam logic [1:0] CFG_GRAV_EN   = 2'd0;
    localparam logic [1:0] CFG_GRAV_VAL  = 2'd1;
    localparam logic [1:0] CFG_NORM_TOL  = 2'd2;

    localparam logic        RST_GRAV_EN  = 1'b1;
    localparam logic [20:0] RST_GRAV_VAL = 21'd642689;
    localparam logic [29:0] RST_NORM_TOL = 30'd10737418;

    // One divider lane: partial remainder, numerator bits then quotient bits,
    // sign of the row entry and the clamped undivided entry.
    typedef struct packed {
        logic [30:0]        rem;
        logic [31:0]        nq;
        logic               neg;
        logic signed [32:0] rc;
    } qva_lane_t;

    typedef struct packed {
        qva_lane_t [NUM_LANES-1:0] lane;
        logic [30:0]               den;
        logic [NUM_LANES-1:0][31:0] accel;
        logic                      renorm;
        logic                      zero;
    } qva_item_t;

    // Exact product, floored to the quaternion fraction
    function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:QUAT_FRAC_BITS];
    endfunction

endpackage

// ===== src/qva_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qva_front
// Products, norm and rotation row, then divider operand setup (3 stages).
// ----------------------------------------------------------------------------
module qva_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    input  logic [29:0]        norm_tolerance,
    output logic               valid,
    output qva_pkg::qva_item_t item
);
    import qva_pkg::*;

    localparam logic signed [36:0] ONE_Q     = 37'sd1 <<< QUAT_FRAC_BITS;
    localparam logic signed [35:0] LIM_POS   = 36'sd1 <<< (QUAT_FRAC_BITS + 1);
    localparam logic signed [35:0] LIM_NEG   = -LIM_POS;

    // stage 1
    logic                        v1_reg;
    logic signed [33:0]          ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [33:0]          xz_reg, wy_reg, yz_reg, wx_reg;
    logic [NUM_LANES-1:0][31:0]  acc1_reg;

    // stage 2
    logic signed [35:0]          n_s;
    logic signed [35:0]          r_s [NUM_LANES];
    logic signed [36:0]          dev_s;
    logic [36:0]                 dev_abs;
    logic                        v2_reg;
    logic [34:0]                 n2_reg;
    logic signed [35:0]          r2_reg [NUM_LANES];
    logic                        renorm2_reg, zero2_reg;
    logic [NUM_LANES-1:0][31:0]  acc2_reg;

    // stage 3
    logic [2:0]                  sh;
    logic [34:0]                 den_w;
    logic [30:0]                 den;
    logic [31:0]                 lim2;
    logic [35:0]                 mag    [NUM_LANES];
    logic [35:0]                 msh    [NUM_LANES];
    logic [31:0]                 m      [NUM_LANES];
    logic [62:0]                 numr   [NUM_LANES];
    qva_item_t                   item_next;
    logic                        v3_reg;
    qva_item_t                   item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg   <= qmul(quat_w, quat_w);
            xx_reg   <= qmul(quat_x, quat_x);
            yy_reg   <= qmul(quat_y, quat_y);
            zz_reg   <= qmul(quat_z, quat_z);
            xz_reg   <= qmul(quat_x, quat_z);
            wy_reg   <= qmul(quat_w, quat_y);
            yz_reg   <= qmul(quat_y, quat_z);
            wx_reg   <= qmul(quat_w, quat_x);
            acc1_reg <= {accel_z, accel_y, accel_x};
        end
    end

    always_comb
    begin
        n_s    = 36'(ww_reg) + 36'(xx_reg) + 36'(yy_reg) + 36'(zz_reg);
        r_s[0] = (36'(xz_reg) - 36'(wy_reg)) <<< 1;
        r_s[1] = (36'(yz_reg) + 36'(wx_reg)) <<< 1;
        r_s[2] = 36'(ww_reg) - 36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg);
        dev_s  = 37'(n_s) - ONE_Q;
        dev_abs = (dev_s < 0) ? 37'(-dev_s) : 37'(dev_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg      <= n_s[34:0];
            r2_reg      <= r_s;
            renorm2_reg <= dev_abs > {7'd0, norm_tolerance};
            zero2_reg   <= (n_s == '0);
            acc2_reg    <= acc1_reg;
        end
    end

    // Scale the divisor below 2^31, clamp the numerator, seed the remainder
    always_comb
    begin
        if (n2_reg[34])
            sh = 3'd4;
        else if (n2_reg[33])
            sh = 3'd3;
        else if (n2_reg[32])
            sh = 3'd2;
        else if (n2_reg[31])
            sh = 3'd1;
        else
            sh = 3'd0;
        den_w = n2_reg >> sh;
        den   = den_w[30:0];
        lim2  = {den, 1'b0};
        item_next        = '0;
        item_next.den    = den;
        item_next.accel  = acc2_reg;
        item_next.renorm = renorm2_reg;
        item_next.zero   = zero2_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag[i]  = (r2_reg[i] < 0) ? 36'(-r2_reg[i]) : 36'(r2_reg[i]);
            msh[i]  = mag[i] >> sh;
            m[i]    = (msh[i] > {4'd0, lim2}) ? lim2 : msh[i][31:0];
            numr[i] = {1'b0, m[i], 30'd0} + {32'd0, den >> 1};
            item_next.lane[i].rem = numr[i][62:32];
            item_next.lane[i].nq  = numr[i][31:0];
            item_next.lane[i].neg = r2_reg[i] < 0;
            if (r2_reg[i] > LIM_POS)
                item_next.lane[i].rc = LIM_POS[32:0];
            else if (r2_reg[i] < LIM_NEG)
                item_next.lane[i].rc = LIM_NEG[32:0];
            else
                item_next.lane[i].rc = r2_reg[i][32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid = v3_reg;
    assign item  = item_reg;

endmodule

// ===== src/qva_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qva_div_step
// One restoring-division step for all three row lanes, registered.
// ----------------------------------------------------------------------------
module qva_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  qva_pkg::qva_item_t in_item,
    output logic               valid,
    output qva_pkg::qva_item_t item
);
    import qva_pkg::*;

    logic [31:0] trial [NUM_LANES];
    logic [31:0] diff  [NUM_LANES];
    logic        qb    [NUM_LANES];
    qva_item_t   item_next;
    logic        valid_reg;
    qva_item_t   item_reg;

    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            // shift in the next numerator bit, subtract if it fits
            trial[i] = {in_item.lane[i].rem, in_item.lane[i].nq[31]};
            diff[i]  = trial[i] - {1'b0, in_item.den};
            qb[i]    = trial[i] >= {1'b0, in_item.den};
            item_next.lane[i].rem = qb[i] ? diff[i][30:0] : trial[i][30:0];
            item_next.lane[i].nq  = {in_item.lane[i].nq[30:0], qb[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== src/qva_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qva_back
// Row entry times acceleration (registered), then sum, gravity and saturation.
// ----------------------------------------------------------------------------
module qva_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  qva_pkg::qva_item_t in_item,
    input  logic               grav_en,
    input  logic [20:0]        grav_value,
    output logic               valid,
    output logic signed [31:0] res_accel,
    output logic               res_renorm,
    output logic               res_sat,
    output logic               res_degen
);
    import qva_pkg::*;

    localparam logic signed [37:0] OUT_MAX = 38'sd2147483647;
    localparam logic signed [37:0] OUT_MIN = -38'sd2147483648;

    logic signed [32:0] q    [NUM_LANES];
    logic signed [32:0] cv   [NUM_LANES];
    logic signed [64:0] prod [NUM_LANES];
    logic               valid_reg;
    logic signed [34:0] p_reg [NUM_LANES];
    logic               renorm_reg, zero_reg;
    logic signed [37:0] sum;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            q[i]    = $signed({1'b0, in_item.lane[i].nq});
            cv[i]   = in_item.renorm ? (in_item.lane[i].neg ? -q[i] : q[i])
                                     : in_item.lane[i].rc;
            prod[i] = 65'(cv[i]) * 65'($signed(in_item.accel[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                p_reg[i] <= prod[i][64:QUAT_FRAC_BITS];
            renorm_reg <= in_item.renorm;
            zero_reg   <= in_item.zero;
        end
    end

    always_comb
    begin
        sum = 38'(p_reg[0]) + 38'(p_reg[1]) + 38'(p_reg[2])
            - (grav_en ? $signed({17'd0, grav_value}) : 38'sd0);
        res_renorm = renorm_reg && !zero_reg;
        res_degen  = zero_reg;
        res_sat    = 1'b0;
        if (zero_reg)
            res_accel = '0;
        else if (sum > OUT_MAX)
        begin
            res_accel = OUT_MAX[31:0];
            res_sat   = 1'b1;
        end
        else if (sum < OUT_MIN)
        begin
            res_accel = OUT_MIN[31:0];
            res_sat   = 1'b1;
        end
        else
            res_accel = sum[31:0];
    end

    assign valid = valid_reg;

endmodule

// ===== src/quaternion_vertical_accel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vertical_accel
// World-frame vertical acceleration from a body vector and a quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries the body acceleration and the
//   quaternion; output channel out_valid/out_ready carries the vertical
//   acceleration and the renormalized, saturated and degenerate_quat flags.
//   Configuration is a write-only port (cfg_write_en, cfg_index, cfg_data);
//   write it only while no item is in flight.
//   From input transfer to out_valid an item passes three front stages
//   (products, norm and row, divider setup), 32 divider stages at one quotient
//   bit each, one multiply stage and the output register. Throughput is one
//   item per cycle unless the receiver stalls; the divider pipeline sets the
//   depth. When the receiver stalls, the output register holds and the pipeline
//   keeps filling until its last stage is occupied; in_ready then drops.
//   Reset empties the pipeline and loads the register defaults (gravity
//   compensation on, 9.80665 m/s^2, tolerance 0.01).
// ----------------------------------------------------------------------------
`include "quaternion_vertical_accel_defines.svh"

module quaternion_vertical_accel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vertical_accel,
    output logic               renormalized,
    output logic               saturated,
    output logic               degenerate_quat,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [29:0]        cfg_data
);
    import qva_pkg::*;

    logic              grav_en_reg,  grav_en_next;
    logic [20:0]       grav_val_reg, grav_val_next;
    logic [29:0]       norm_tol_reg, norm_tol_next;

    logic              en;
    logic              load_ok;
    logic              front_valid;
    qva_item_t         front_item;
    logic              div_valid [DIV_STEPS+1];
    qva_item_t         div_item  [DIV_STEPS+1];
    logic              back_valid;
    logic signed [31:0] res_accel;
    logic              res_renorm, res_sat, res_degen;

    logic              out_valid_reg;
    logic signed [31:0] accel_out_reg;
    logic              renorm_out_reg, sat_out_reg, degen_out_reg;

    always_comb
    begin
        grav_en_next  = grav_en_reg;
        grav_val_next = grav_val_reg;
        norm_tol_next = norm_tol_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_GRAV_EN:  grav_en_next  = cfg_data[0];
                CFG_GRAV_VAL: grav_val_next = cfg_data[20:0];
                CFG_NORM_TOL: norm_tol_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_en_reg  <= RST_GRAV_EN;
            grav_val_reg <= RST_GRAV_VAL;
            norm_tol_reg <= RST_NORM_TOL;
        end
        else
        begin
            grav_en_reg  <= grav_en_next;
            grav_val_reg <= grav_val_next;
            norm_tol_reg <= norm_tol_next;
        end
    end

    // Advance the pipeline unless its last stage holds a result with nowhere to go
    assign load_ok  = !out_valid_reg || out_ready;
    assign en       = !back_valid || load_ok;
    assign in_ready = en;

    qva_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .quat_w         (quat_w),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z),
        .norm_tolerance (norm_tol_reg),
        .valid          (front_valid),
        .item           (front_item)
    );

    assign div_valid[0] = front_valid;
    assign div_item[0]  = front_item;

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        qva_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (div_valid[s]),
            .in_item  (div_item[s]),
            .valid    (div_valid[s+1]),
            .item     (div_item[s+1])
        );
    end

    qva_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid[DIV_STEPS]),
        .in_item    (div_item[DIV_STEPS]),
        .grav_en    (grav_en_reg),
        .grav_value (grav_val_reg),
        .valid      (back_valid),
        .res_accel  (res_accel),
        .res_renorm (res_renorm),
        .res_sat    (res_sat),
        .res_degen  (res_degen)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_ok)
            out_valid_reg <= back_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && back_valid)
        begin
            accel_out_reg  <= res_accel;
            renorm_out_reg <= res_renorm;
            sat_out_reg    <= res_sat;
            degen_out_reg  <= res_degen;
        end
    end

    assign out_valid       = out_valid_reg;
    assign vertical_accel  = accel_out_reg;
    assign renormalized    = renorm_out_reg;
    assign saturated       = sat_out_reg;
    assign degenerate_quat = degen_out_reg;

    `QVA_ASSERT_NOW(a_degen_clean, out_valid_reg && degen_out_reg,
        !renorm_out_reg && !sat_out_reg && (accel_out_reg == '0),
        "degenerate result carries other flags or a nonzero value")
    `QVA_ASSERT_NOW(a_sat_at_limit, out_valid_reg && sat_out_reg,
        (accel_out_reg == 32'sh7FFF_FFFF) || (accel_out_reg == 32'sh8000_0000),
        "saturated result not at an output limit")
    `QVA_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready,
        "pipeline stalled while the output register is empty")
    `QVA_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready,
        out_valid_reg && $stable(accel_out_reg),
        "stalled output result changed")

endmodule

// ===== verif/tb_quaternion_vertical_accel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vertical_accel
// Self-checking bench for the vertical acceleration pipeline.
// ----------------------------------------------------------------------------
// Each accepted input transfer is run through a local fixed-point model of the
// rotation row, renormalization, gravity and saturation. The expected result
// is queued, and every output transfer is compared field by field with the
// oldest entry. Directed corners come first, then random unit and
// near-unit quaternions under several register settings, with random stalls
// on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_quaternion_vertical_accel;
    import qva_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam longint     Q_ONE     = 64'sd1 << 30;
    localparam longint     ROW_LIM   = 64'sd1 << 31;

    typedef struct {
        logic signed [31:0] accel;
        logic               renorm;
        logic               sat;
        logic               degen;
    } vert_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] accel_x, accel_y, accel_z;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] vertical_accel;
    logic renormalized, saturated, degenerate_quat;
    logic cfg_write_en;
    logic [1:0] cfg_index;
    logic [29:0] cfg_data;

    // register mirror
    logic        grav_en_m;
    logic [20:0] grav_val_m;
    logic [29:0] norm_tol_m;

    vert_result_t expected_q[$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  renorm_seen;
    int  sat_seen;
    int  degen_seen;
    bit  gaps_on;
    bit  stalls_on;
    int  hold_req;

    quaternion_vertical_accel dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertical_accel(vertical_accel), .renormalized(renormalized),
        .saturated(saturated), .degenerate_quat(degenerate_quat),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sq_floor(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 30;
    endfunction

    // divide a row entry by the norm, rounding half up on the magnitude
    function automatic longint row_over_norm(longint num, longint den);
        longint unsigned m;
        longint unsigned d;
        longint unsigned qv;
        m = (num < 0) ? longint'(-num) : longint'(num);
        d = den;
        while (d >= (64'd1 << 31))
        begin
            m = m >> 1;
            d = d >> 1;
        end
        if (m > 2 * d)
            m = 2 * d;
        qv = ((m << 30) + (d >> 1)) / d;
        return (num < 0) ? -longint'(qv) : longint'(qv);
    endfunction

    function automatic vert_result_t predict_vertical(
        logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
        logic signed [31:0] qw, logic signed [31:0] qx, logic signed [31:0] qy,
        logic signed [31:0] qz);
        vert_result_t res;
        longint w, x, y, z, ww, xx, yy, zz, nrm, dev, sum, c;
        longint row[3];
        longint acc[3];
        w = qw; x = qx; y = qy; z = qz;
        acc[0] = ax; acc[1] = ay; acc[2] = az;
        ww = sq_floor(w, w);
        xx = sq_floor(x, x);
        yy = sq_floor(y, y);
        zz = sq_floor(z, z);
        nrm = ww + xx + yy + zz;
        res = '{accel: '0, renorm: 1'b0, sat: 1'b0, degen: 1'b0};
        if (nrm == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        row[0] = 2 * (sq_floor(x, z) - sq_floor(w, y));
        row[1] = 2 * (sq_floor(y, z) + sq_floor(w, x));
        row[2] = ww - xx - yy + zz;
        dev = nrm - Q_ONE;
        if (dev < 0)
            dev = -dev;
        res.renorm = dev > longint'(norm_tol_m);
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            c = res.renorm ? row_over_norm(row[i], nrm) : row[i];
            if (c > ROW_LIM)
                c = ROW_LIM;
            if (c < -ROW_LIM)
                c = -ROW_LIM;
            sum += (c * acc[i]) >>> 30;
        end
        if (grav_en_m)
            sum -= longint'(grav_val_m);
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.accel = sum[31:0];
        return res;
    endfunction

    // queue the expected result on every input transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_q.push_back(predict_vertical(accel_x, accel_y, accel_z,
                                                  quat_w, quat_x, quat_y, quat_z));
    end

    always @(posedge clk)
    begin
        vert_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result accel=%0d", $time, vertical_accel);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                renorm_seen += exp_r.renorm;
                sat_seen    += exp_r.sat;
                degen_seen  += exp_r.degen;
                if (vertical_accel !== exp_r.accel)
                begin
                    errors++;
                    $display("%0t: vertical_accel expected %0d actual %0d",
                             $time, exp_r.accel, vertical_accel);
                end
                if (renormalized !== exp_r.renorm)
                begin
                    errors++;
                    $display("%0t: renormalized expected %0b actual %0b",
                             $time, exp_r.renorm, renormalized);
                end
                if (saturated !== exp_r.sat)
                begin
                    errors++;
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, exp_r.sat, saturated);
                end
                if (degenerate_quat !== exp_r.degen)
                begin
                    errors++;
                    $display("%0t: degenerate_quat expected %0b actual %0b",
                             $time, exp_r.degen, degenerate_quat);
                end
            end
        end
    end

    // receiver: random stall before each transfer, or a long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            else if (stalls_on)
            begin
                stall = $urandom_range(0, 15);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_item(logic signed [31:0] ax, logic signed [31:0] ay,
                             logic signed [31:0] az, logic signed [31:0] qw,
                             logic signed [31:0] qx, logic signed [31:0] qy,
                             logic signed [31:0] qz);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        accel_x <= ax; accel_y <= ay; accel_z <= az;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // drop valid and let the pipeline drain
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(logic en, logic [20:0] gval, logic [29:0] tol);
        logic [1:0]  idx[4];
        logic [29:0] val[4];
        idx = '{CFG_GRAV_EN, CFG_GRAV_VAL, CFG_NORM_TOL, CFG_SPARE};
        val = '{{29'd0, en}, {9'd0, gval}, tol, 30'h3FFF_FFFF};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[i];
            cfg_data     <= val[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        grav_en_m  = en;
        grav_val_m = gval;
        norm_tol_m = tol;
    endtask

    function automatic logic signed [31:0] rand_accel();
        if ($urandom_range(0, 9) < 8)
            return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        return $urandom;
    endfunction

    // unit quaternion in Q2.30 with a small scale error around the tolerance, or a large one when far_off is set
    task automatic send_attitude_item(bit far_off);
        real w, x, y, z, nrm, k;
        w = real'($urandom_range(0, 2000)) - 1000.0;
        x = real'($urandom_range(0, 2000)) - 1000.0;
        y = real'($urandom_range(0, 2000)) - 1000.0;
        z = real'($urandom_range(0, 2000)) - 1000.0;
        nrm = $sqrt(w * w + x * x + y * y + z * z);
        if (nrm == 0.0)
        begin
            w = 1.0;
            nrm = 1.0;
        end
        k = far_off ? real'($urandom_range(10, 190)) / 100.0
                    : 1.0 + (real'($urandom_range(0, 200)) - 100.0) / 10000.0;
        k = k * 1073741824.0 / nrm;
        send_item(rand_accel(), rand_accel(), rand_accel(),
                  $rtoi(w * k), $rtoi(x * k), $rtoi(y * k), $rtoi(z * k));
    endtask

    task automatic send_random_mix(int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       send_item($urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom);
                1:       send_attitude_item(1'b1);
                default: send_attitude_item(1'b0);
            endcase
        end
    endtask

    task automatic test_corners;
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        localparam logic signed [31:0] ONE  = 32'sh4000_0000;
        gaps_on = 1'b1;
        send_item(0, 0, 32'sd642689, ONE, 0, 0, 0);
        send_item(MAXV, MINV, MAXV, ONE, 0, 0, 0);
        send_item(MINV, MAXV, MINV, ONE, 0, 0, 0);
        send_item(100, 200, 300, 0, 0, 0, 0);          // all-zero quaternion
        send_item(100, 200, 300, 1, -1, 1, -1);        // squares floor to zero
        send_item(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_item(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_item(MAXV, MINV, -1, MINV, MAXV, MINV, MAXV);
        send_item(1 << 16, 2 << 16, 3 << 16, 0, ONE, 0, 0);
        send_item(1 << 16, 2 << 16, 3 << 16, 0, 0, ONE, 0);
        send_item(1 << 16, 2 << 16, 3 << 16, 0, 0, 0, ONE);
        send_item(-1, -1, -1, 32'sh2D41_3CCD, 32'sh2D41_3CCD, 0, 0);
        send_item(5 << 16, -7 << 16, 9 << 16, 32'sh2000_0000, 0, 0, 0);
        send_item(5 << 16, -7 << 16, 9 << 16, 32'sh4051_EB85, 0, 0, 0);
        send_item(0, 0, MINV, 32'sh4000_0001, 0, 0, 0);
        drain();
    endtask

    task automatic test_register_extremes;
        // gravity off, no tolerance: every off-unit quaternion renormalizes
        set_config(1'b0, 21'd0, 30'd0);
        send_item(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh4000_0000, 0, 0, 0);
        send_item(0, 0, 32'sh7FFF_FFFF, 32'sh4000_0001, 0, 0, 0);
        send_random_mix(250);
        drain();
        // largest gravity and tolerance: the row clamp engages on big quaternions
        set_config(1'b1, 21'h1F_FFFF, 30'h3FFF_FFFF);
        send_item(32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
        send_item(0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_random_mix(250);
        drain();
    endtask

    task automatic test_random_settings;
        for (int p = 0; p < 2; p++)
        begin
            set_config(1'($urandom_range(0, 1)), 21'($urandom_range(0, 21'h1F_FFFF)),
                       30'($urandom_range(0, 30'd50_000_000)));
            send_random_mix(150);
            drain();
        end
        set_config(RST_GRAV_EN, RST_GRAV_VAL, RST_NORM_TOL);
    endtask

    // a stretch with no idling on either side
    task automatic test_full_rate;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random_mix(120);
        drain();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // hold the receiver so the pipeline fills and input ready drops
    task automatic test_backpressure;
        gaps_on  = 1'b0;
        hold_req = 150;
        send_random_mix(100);
        gaps_on  = 1'b1;
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_GRAV_EN;
        cfg_data     = '0;
        grav_en_m    = RST_GRAV_EN;
        grav_val_m   = RST_GRAV_VAL;
        norm_tol_m   = RST_NORM_TOL;
        errors = 0; items_sent = 0; results_seen = 0;
        renorm_seen = 0; sat_seen = 0; degen_seen = 0;
        gaps_on = 1'b1; stalls_on = 1'b1; hold_req = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        send_random_mix(200);
        drain();
        test_register_extremes();
        test_random_settings();
        test_full_rate();
        test_backpressure();

        $display("Sent %0d items, checked %0d results under default, extreme and random",
                 items_sent, results_seen);
        $display("registers: %0d renormalized, %0d saturated, %0d degenerate",
                 renorm_seen, sat_seen, degen_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
